### rtl/core/assert_macros.svh
// Assertion macros used by the transform engine sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property that holds on every clock edge outside reset.
`define AST_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication checked on every clock edge outside reset.
`define AST_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`endif

### rtl/core/a3d_pkg.sv
// Shared types and constants of the 3D affine transform engine.
package a3d_pkg;
    localparam logic [2:0] ACT_IDENT = 3'd0;
    localparam logic [2:0] ACT_TRANS = 3'd1;
    localparam logic [2:0] ACT_SCALE = 3'd2;
    localparam logic [2:0] ACT_ROT   = 3'd3;
    localparam logic [2:0] ACT_POINT = 3'd4;

    localparam int AngleFull    = 23040;
    localparam int AngleHalf    = 11520;
    localparam int AngleQuarter = 5760;
    localparam int CordicFrac   = 30;
    localparam longint CordicGain = 652032874;
    localparam int AtanCount    = 24;

    // Datapath operation codes.
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_IDENT = 3'd1,
        OP_TRANS = 3'd2,
        OP_ANGLE = 3'd3,
        OP_CSTEP = 3'd4,
        OP_CFIN  = 3'd5,
        OP_MAC   = 3'd6,
        OP_WRITE = 3'd7
    } t_op;

    // Which operand matrix a product uses.
    typedef enum logic [1:0] {
        MS_SCALE = 2'd0,
        MS_RX    = 2'd1,
        MS_RY    = 2'd2,
        MS_RZ    = 2'd3
    } t_msel;

    typedef struct packed {
        t_op         op;
        t_msel       msel;
        logic [1:0]  axis;   // angle source for OP_ANGLE
        logic [4:0]  step;   // CORDIC step
        logic [3:0]  entry;  // matrix entry r*3+c
        logic [1:0]  k;      // term index
        logic        emit;   // point mode: sum goes to output register
    } t_cmd;

    typedef struct packed {
        logic angle_done;
    } t_stat;

    function automatic longint atan_val(input logic [4:0] i);
        unique case (i)
            5'd0:  return 188743680; 5'd1:  return 111421900;
            5'd2:  return 58872272;  5'd3:  return 29884485;
            5'd4:  return 15000234;  5'd5:  return 7507429;
            5'd6:  return 3754631;   5'd7:  return 1877430;
            5'd8:  return 938729;    5'd9:  return 469366;
            5'd10: return 234683;    5'd11: return 117342;
            5'd12: return 58671;     5'd13: return 29335;
            5'd14: return 14668;     5'd15: return 7334;
            5'd16: return 3667;      5'd17: return 1833;
            5'd18: return 917;       5'd19: return 458;
            5'd20: return 229;       5'd21: return 115;
            5'd22: return 57;        5'd23: return 29;
            default: return 0;
        endcase
    endfunction
endpackage

### rtl/core/a3d_ctrl.sv
// Sequencer of the transform engine: walks actions through the datapath.
`include "assert_macros.svh"
module a3d_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [2:0]    i_action,
    output logic          o_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output a3d_pkg::t_cmd o_cmd,
    input  a3d_pkg::t_stat i_stat
);
    localparam int NSteps = (CORDIC_STEPS < a3d_pkg::AtanCount) ? CORDIC_STEPS
                                                                : a3d_pkg::AtanCount;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b0_0000_0001,
        S_ANGLE = 9'b0_0000_0010,
        S_CORD  = 9'b0_0000_0100,
        S_CFIN  = 9'b0_0000_1000,
        S_MAC   = 9'b0_0001_0000,
        S_WRITE = 9'b0_0010_0000,
        S_PMAC  = 9'b0_0100_0000,
        S_PWR   = 9'b0_1000_0000,
        S_TRANS = 9'b1_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic [2:0] r_act, n_act;
    logic [1:0] r_axis, n_axis;
    logic [4:0] r_step, n_step;
    logic [3:0] r_entry, n_entry;
    logic [1:0] r_k, n_k;
    logic       r_oval, n_oval;
    logic       acc_in;
    logic       busy;

    assign busy   = (r_state != S_IDLE);
    assign o_stall = busy;
    assign acc_in = i_valid && !o_stall;
    assign o_out_valid = r_oval;

    always_comb begin
        n_state = r_state;
        n_act = r_act;
        n_axis = r_axis;
        n_step = r_step;
        n_entry = r_entry;
        n_k = r_k;
        n_oval = r_oval;
        o_cmd = '0;
        o_cmd.op = a3d_pkg::OP_NONE;
        o_cmd.msel = (r_act == a3d_pkg::ACT_SCALE) ? a3d_pkg::MS_SCALE :
                     (r_axis == 2'd0) ? a3d_pkg::MS_RX :
                     (r_axis == 2'd1) ? a3d_pkg::MS_RY : a3d_pkg::MS_RZ;
        o_cmd.axis = r_axis;
        o_cmd.step = r_step;
        o_cmd.entry = r_entry;
        o_cmd.k = r_k;
        if (r_oval && !i_out_stall) begin
            n_oval = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (acc_in) begin
                    n_act = i_action;
                    n_axis = 2'd0;
                    n_step = '0;
                    n_entry = '0;
                    n_k = '0;
                    unique case (i_action)
                        a3d_pkg::ACT_IDENT: o_cmd.op = a3d_pkg::OP_IDENT;
                        a3d_pkg::ACT_TRANS: n_state = S_TRANS;
                        a3d_pkg::ACT_SCALE: n_state = S_MAC;
                        a3d_pkg::ACT_ROT:   n_state = S_ANGLE;
                        a3d_pkg::ACT_POINT: n_state = S_PMAC;
                        default: ;
                    endcase
                end
            end
            S_TRANS: begin
                // offsets are in the argument registers by now
                o_cmd.op = a3d_pkg::OP_TRANS;
                n_state = S_IDLE;
            end
            S_ANGLE: begin
                o_cmd.op = a3d_pkg::OP_ANGLE;
                n_step = '0;
                n_state = S_CORD;
            end
            S_CORD: begin
                o_cmd.op = a3d_pkg::OP_CSTEP;
                n_step = r_step + 5'd1;
                if (32'(r_step) == NSteps - 1) n_state = S_CFIN;
            end
            S_CFIN: begin
                o_cmd.op = a3d_pkg::OP_CFIN;
                n_state = S_MAC;
            end
            S_MAC: begin
                o_cmd.op = a3d_pkg::OP_MAC;
                n_k = r_k + 2'd1;
                if (r_k == 2'd2) n_state = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.op = a3d_pkg::OP_WRITE;
                n_k = '0;
                if (r_entry == 4'd11) begin
                    n_entry = '0;
                    if (r_act == a3d_pkg::ACT_ROT && r_axis != 2'd2) begin
                        n_axis = r_axis + 2'd1;
                        n_state = S_ANGLE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_entry = r_entry + 4'd1;
                    n_state = S_MAC;
                end
            end
            S_PMAC: begin
                o_cmd.op = a3d_pkg::OP_MAC;
                o_cmd.emit = 1'b1;
                n_k = r_k + 2'd1;
                if (r_k == 2'd2) n_state = S_PWR;
            end
            S_PWR: begin
                o_cmd.emit = 1'b1;
                if (r_entry == 4'd2) begin
                    // hold the last column until the output register frees up
                    if (!r_oval || !i_out_stall) begin
                        o_cmd.op = a3d_pkg::OP_WRITE;
                        n_k = '0;
                        n_entry = '0;
                        n_oval = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.op = a3d_pkg::OP_WRITE;
                    n_k = '0;
                    n_entry = r_entry + 4'd1;
                    n_state = S_PMAC;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_oval <= 1'b0;
            r_act <= '0;
            r_axis <= '0;
            r_step <= '0;
            r_entry <= '0;
            r_k <= '0;
        end else begin
            r_state <= n_state;
            r_oval <= n_oval;
            r_act <= n_act;
            r_axis <= n_axis;
            r_step <= n_step;
            r_entry <= n_entry;
            r_k <= n_k;
        end
    end

    `AST_IMPLY(a_no_accept_busy, i_clk, i_rst_n, busy, o_stall, "input taken while busy")
    `AST_IMPLY(a_angle_seen, i_clk, i_rst_n, r_state == S_CORD && r_step == '0,
        i_stat.angle_done, "CORDIC started without angle")
    `AST_IMPLY(a_emit_idle, i_clk, i_rst_n, $rose(r_oval), $past(r_state) == S_PWR,
        "result raised outside point write")
endmodule

### rtl/core/a3d_dp.sv
// Datapath: matrix store, CORDIC, shared multiplier and accumulator.
module a3d_dp #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic signed [31:0]  i_arg_x,
    input  logic signed [31:0]  i_arg_y,
    input  logic signed [31:0]  i_arg_z,
    input  a3d_pkg::t_cmd       i_cmd,
    output a3d_pkg::t_stat      o_stat,
    output logic signed [31:0]  o_out_x,
    output logic signed [31:0]  o_out_y,
    output logic signed [31:0]  o_out_z
);
    localparam longint One = 64'sd1 <<< FRAC_BITS;
    localparam int CSh = a3d_pkg::CordicFrac - FRAC_BITS;
    // 23040 = 512 * 45: keep the low 9 bits, reduce the rest modulo 45
    localparam logic [24:0] AngleRecip = 25'd23860930;
    localparam logic signed [24:0] AngleOfs = 25'sd5898240;

    logic signed [31:0] r_mat [12];
    logic signed [31:0] r_nm  [12];
    logic signed [31:0] r_ax, r_ay, r_az;
    logic signed [33:0] r_cx, r_cy;
    logic signed [47:0] r_cz;
    logic signed [31:0] r_sn, r_cs;
    logic               r_flip;
    logic               r_angle_ok;
    logic signed [57:0] r_acc;
    logic signed [31:0] r_px, r_py;

    // Angle reduction for the selected axis.
    logic signed [31:0] ang;
    logic signed [24:0] a_h;
    logic [23:0]        a_u;
    logic [48:0]        a_pm;
    logic [23:0]        a_rf;
    logic signed [15:0] a_mod, a_red;
    logic               a_flip;
    always_comb begin
        ang = (i_cmd.axis == 2'd0) ? r_ax : (i_cmd.axis == 2'd1) ? r_ay : r_az;
        a_h = 25'(ang >>> 9) + AngleOfs;
        a_u = a_h[23:0];
        a_pm = 49'(a_u) * 49'(AngleRecip);
        a_rf = a_u - 24'(a_pm[48:30]) * 24'd45;
        a_mod = signed'(16'({a_rf[5:0], ang[8:0]}));
        if (a_mod > 16'sd11520) a_mod = a_mod - 16'sd23040;
        a_flip = 1'b0;
        a_red = a_mod;
        if (a_mod > 16'sd5760) begin
            a_red = a_mod - 16'sd11520;
            a_flip = 1'b1;
        end else if (a_mod < -16'sd5760) begin
            a_red = a_mod + 16'sd11520;
            a_flip = 1'b1;
        end
    end

    // One CORDIC rotation step.
    logic signed [47:0] atv;
    logic signed [33:0] sx, sy;
    always_comb begin
        atv = 48'(a3d_pkg::atan_val(i_cmd.step));
        sx = r_cx >>> i_cmd.step;
        sy = r_cy >>> i_cmd.step;
    end

    // Final CORDIC rounding and clamp.
    logic signed [33:0] fx, fy;
    always_comb begin
        fx = (r_cx + (34'sd1 <<< (CSh - 1))) >>> CSh;
        fy = (r_cy + (34'sd1 <<< (CSh - 1))) >>> CSh;
        if (fx > 34'(One)) fx = 34'(One);
        if (fx < -34'(One)) fx = -34'(One);
        if (fy > 34'(One)) fy = 34'(One);
        if (fy < -34'(One)) fy = -34'(One);
    end

    // Operand selection for one product term.
    logic [1:0] row, col;
    logic signed [31:0] opa, opb;
    always_comb begin
        unique case (i_cmd.entry)
            4'd0:  {row, col} = 4'b00_00;
            4'd1:  {row, col} = 4'b00_01;
            4'd2:  {row, col} = 4'b00_10;
            4'd3:  {row, col} = 4'b01_00;
            4'd4:  {row, col} = 4'b01_01;
            4'd5:  {row, col} = 4'b01_10;
            4'd6:  {row, col} = 4'b10_00;
            4'd7:  {row, col} = 4'b10_01;
            4'd8:  {row, col} = 4'b10_10;
            4'd9:  {row, col} = 4'b11_00;
            4'd10: {row, col} = 4'b11_01;
            4'd11: {row, col} = 4'b11_10;
            default: {row, col} = 4'b00_00;
        endcase
        opb = '0;
        if (i_cmd.emit) begin
            opa = (i_cmd.k == 2'd0) ? r_ax : (i_cmd.k == 2'd1) ? r_ay : r_az;
            opb = r_mat[4'(i_cmd.k) * 4'd3 + {2'b00, i_cmd.entry[1:0]}];
        end else begin
            opa = r_mat[4'(row) * 4'd3 + 4'(i_cmd.k)];
            unique case (i_cmd.msel)
                a3d_pkg::MS_SCALE: begin
                    if (i_cmd.k == col)
                        opb = (col == 2'd0) ? r_ax : (col == 2'd1) ? r_ay : r_az;
                end
                a3d_pkg::MS_RX: begin
                    unique case ({i_cmd.k, col})
                        4'b0000: opb = 32'(One);
                        4'b0101, 4'b1010: opb = r_cs;
                        4'b0110: opb = r_sn;
                        4'b1001: opb = -r_sn;
                        default: opb = '0;
                    endcase
                end
                a3d_pkg::MS_RY: begin
                    unique case ({i_cmd.k, col})
                        4'b0000, 4'b1010: opb = r_cs;
                        4'b0010: opb = -r_sn;
                        4'b0101: opb = 32'(One);
                        4'b1000: opb = r_sn;
                        default: opb = '0;
                    endcase
                end
                a3d_pkg::MS_RZ: begin
                    unique case ({i_cmd.k, col})
                        4'b0000, 4'b0101: opb = r_cs;
                        4'b0001: opb = r_sn;
                        4'b0100: opb = -r_sn;
                        4'b1010: opb = 32'(One);
                        default: opb = '0;
                    endcase
                end
                default: opb = '0;
            endcase
        end
    end

    // Combinational product, rounded and then accumulated into a register.
    logic signed [63:0] prod;
    logic signed [57:0] rnd;
    assign prod = opa * opb;
    assign rnd = 58'((prod + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);

    logic signed [57:0] tot;
    logic signed [31:0] satv;
    logic signed [37:0] tr;
    always_comb begin
        tot = r_acc;
        if (i_cmd.emit) tot = r_acc + 58'(r_mat[4'd9 + {2'b00, i_cmd.entry[1:0]}]);
        if (tot > 58'sd2147483647) satv = 32'sh7fffffff;
        else if (tot < -58'sd2147483648) satv = 32'sh80000000;
        else satv = 32'(tot);
    end

    logic signed [31:0] trs [3];
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            tr = 38'(r_mat[9 + j]) +
                 38'((64'(j == 0 ? r_ax : j == 1 ? r_ay : r_az)) <<< FRAC_BITS);
            if (38'(64'(j == 0 ? r_ax : j == 1 ? r_ay : r_az) <<< FRAC_BITS) != 38'((64'(
                j == 0 ? r_ax : j == 1 ? r_ay : r_az)) <<< FRAC_BITS) || tr > 38'sd2147483647)
                trs[j] = (r_ax[31] && j == 0) || (r_ay[31] && j == 1) || (r_az[31] && j == 2)
                         ? 32'sh80000000 : 32'sh7fffffff;
            else if (tr < -38'sd2147483648) trs[j] = 32'sh80000000;
            else trs[j] = 32'(tr);
        end
    end

    // Offset shift may exceed 38 bits; detect with a 64-bit check.
    logic [2:0] big;
    always_comb begin
        for (int j = 0; j < 3; j++)
            big[j] = ((64'(j == 0 ? r_ax : j == 1 ? r_ay : r_az)) <<< FRAC_BITS) > 64'sd4294967295
                  || ((64'(j == 0 ? r_ax : j == 1 ? r_ay : r_az)) <<< FRAC_BITS) < -64'sd4294967296;
    end

    assign o_stat.angle_done = r_angle_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 12; i++)
                r_mat[i] <= (i == 0 || i == 4 || i == 8) ? 32'(One) : '0;
            r_angle_ok <= 1'b0;
        end else begin
            if (i_load) begin
                r_ax <= i_arg_x;
                r_ay <= i_arg_y;
                r_az <= i_arg_z;
            end
            unique case (i_cmd.op)
                a3d_pkg::OP_IDENT: begin
                    for (int i = 0; i < 12; i++)
                        r_mat[i] <= (i == 0 || i == 4 || i == 8) ? 32'(One) : '0;
                end
                a3d_pkg::OP_TRANS: begin
                    for (int j = 0; j < 3; j++) begin
                        if (big[j] && ((j == 0 && r_ax[31]) || (j == 1 && r_ay[31]) ||
                                       (j == 2 && r_az[31])))
                            r_mat[9 + j] <= 32'sh80000000;
                        else if (big[j])
                            r_mat[9 + j] <= 32'sh7fffffff;
                        else
                            r_mat[9 + j] <= trs[j];
                    end
                end
                a3d_pkg::OP_ANGLE: begin
                    r_cx <= 34'(a3d_pkg::CordicGain);
                    r_cy <= '0;
                    r_cz <= 48'(a_red) <<< 16;
                    r_flip <= a_flip;
                    r_angle_ok <= 1'b1;
                end
                a3d_pkg::OP_CSTEP: begin
                    if (r_cz >= 0) begin
                        r_cx <= r_cx - sy;
                        r_cy <= r_cy + sx;
                        r_cz <= r_cz - atv;
                    end else begin
                        r_cx <= r_cx + sy;
                        r_cy <= r_cy - sx;
                        r_cz <= r_cz + atv;
                    end
                end
                a3d_pkg::OP_CFIN: begin
                    r_cs <= r_flip ? -32'(fx) : 32'(fx);
                    r_sn <= r_flip ? -32'(fy) : 32'(fy);
                    r_angle_ok <= 1'b0;
                end
                a3d_pkg::OP_MAC: begin
                    r_acc <= (i_cmd.k == 2'd0) ? rnd : r_acc + rnd;
                end
                a3d_pkg::OP_WRITE: begin
                    if (i_cmd.emit) begin
                        // stage x and y, publish the whole point with z
                        unique case (i_cmd.entry[1:0])
                            2'd0: r_px <= satv;
                            2'd1: r_py <= satv;
                            default: begin
                                o_out_x <= r_px;
                                o_out_y <= r_py;
                                o_out_z <= satv;
                            end
                        endcase
                    end else begin
                        r_nm[i_cmd.entry] <= satv;
                        // commit the whole matrix once the last entry is done
                        if (i_cmd.entry == 4'd11) begin
                            for (int i = 0; i < 11; i++) r_mat[i] <= r_nm[i];
                            r_mat[11] <= satv;
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

### rtl/core/affine_3d_transform_engine.sv
// Identity completes at the edge that accepts it. Translate, scale and point run
// through the sequencer; a point waits in its last write while the output register
// is held. Rotate runs three passes of angle setup, CORDIC steps, rounding and
// a matrix product. One item at a time; a waiting result does
// not block input. Synchronous active-low reset restores the identity
// matrix and empties the output register.
module affine_3d_transform_engine #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_action,
    input  logic signed [31:0] i_arg_x,
    input  logic signed [31:0] i_arg_y,
    input  logic signed [31:0] i_arg_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z
);
    a3d_pkg::t_cmd  cmd;
    a3d_pkg::t_stat stat;

    a3d_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_action(i_action),
        .o_stall(o_stall), .o_out_valid(o_valid), .i_out_stall(i_stall),
        .o_cmd(cmd), .i_stat(stat)
    );

    a3d_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(i_valid && !o_stall),
        .i_arg_x(i_arg_x), .i_arg_y(i_arg_y), .i_arg_z(i_arg_z),
        .i_cmd(cmd), .o_stat(stat),
        .o_out_x(o_out_x), .o_out_y(o_out_y), .o_out_z(o_out_z)
    );
endmodule

### sim/tb.sv
// Self-checking testbench for the 3D affine transform engine.
module tb;
    typedef struct {
        logic [2:0]  action;
        logic [31:0] ax, ay, az;
    } t_item;

    typedef struct {
        logic [31:0] x, y, z;
    } t_point;

    localparam int  FRAC  = 16;
    localparam int  STEPS = 16;
    localparam longint ONE = longint'(1) << FRAC;
    localparam int  LIMIT = 3000000;
    localparam int  DRAIN = 400;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [2:0]         i_action = '0;
    logic signed [31:0] i_arg_x = '0;
    logic signed [31:0] i_arg_y = '0;
    logic signed [31:0] i_arg_z = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_out_x, o_out_y, o_out_z;

    affine_3d_transform_engine dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_item  pending_items[$];
    t_point expected_points[$];
    longint mat[12];
    int     errors = 0;
    int     points_seen = 0;
    int     rotations_sent = 0;
    int     items_sent = 0;
    longint cycles = 0;

    // ---------------- prediction ----------------
    function automatic longint fshift(longint v, int sh);
        return v >>> sh;
    endfunction

    function automatic longint rshift(longint v, int sh);
        return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return rshift(a * b, FRAC);
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint atan_tab(int i);
        longint tab[24] = '{188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
                            3754631, 1877430, 938729, 469366, 234683, 117342,
                            58671, 29335, 14668, 7334, 3667, 1833,
                            917, 458, 229, 115, 57, 29};
        return tab[i];
    endfunction

    function automatic void angle_sin_cos(longint angle, output longint sn, output longint cs);
        longint a, x, y, z, nx;
        bit flip;
        a = angle % a3d_pkg::AngleFull;
        flip = 0;
        x = a3d_pkg::CordicGain;
        y = 0;
        if (a < 0) a += a3d_pkg::AngleFull;
        if (a > a3d_pkg::AngleHalf) a -= a3d_pkg::AngleFull;
        if (a > a3d_pkg::AngleQuarter) begin
            a -= a3d_pkg::AngleHalf;
            flip = 1;
        end else if (a < -a3d_pkg::AngleQuarter) begin
            a += a3d_pkg::AngleHalf;
            flip = 1;
        end
        z = a * 65536;
        for (int i = 0; i < STEPS && i < a3d_pkg::AtanCount; i++) begin
            if (z >= 0) begin
                nx = x - fshift(y, i);
                y  = y + fshift(x, i);
                z -= atan_tab(i);
            end else begin
                nx = x + fshift(y, i);
                y  = y - fshift(x, i);
                z += atan_tab(i);
            end
            x = nx;
        end
        x = rshift(x, a3d_pkg::CordicFrac - FRAC);
        y = rshift(y, a3d_pkg::CordicFrac - FRAC);
        if (x > ONE) x = ONE;
        if (x < -ONE) x = -ONE;
        if (y > ONE) y = ONE;
        if (y < -ONE) y = -ONE;
        if (flip) begin
            x = -x;
            y = -y;
        end
        sn = y;
        cs = x;
    endfunction

    function automatic void matrix_post_mul(longint r[9]);
        longint nm[12];
        longint acc;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 3; j++) begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc += qmul(mat[i*3+k], r[k*3+j]);
                nm[i*3+j] = sat32(acc);
            end
        mat = nm;
    endfunction

    function automatic void matrix_identity();
        foreach (mat[i]) mat[i] = 0;
        mat[0] = ONE;
        mat[4] = ONE;
        mat[8] = ONE;
    endfunction

    function automatic void apply_action(t_item it);
        longint ax, ay, az, s, c, acc;
        longint r[9];
        t_point p;
        logic [31:0] o[3];
        ax = longint'(signed'(it.ax));
        ay = longint'(signed'(it.ay));
        az = longint'(signed'(it.az));
        case (it.action)
            a3d_pkg::ACT_IDENT: matrix_identity();
            a3d_pkg::ACT_TRANS: begin
                mat[9]  = sat32(mat[9] + ax * ONE);
                mat[10] = sat32(mat[10] + ay * ONE);
                mat[11] = sat32(mat[11] + az * ONE);
            end
            a3d_pkg::ACT_SCALE: begin
                r = '{ax, 0, 0, 0, ay, 0, 0, 0, az};
                matrix_post_mul(r);
            end
            a3d_pkg::ACT_ROT: begin
                angle_sin_cos(ax, s, c);
                r = '{ONE, 0, 0, 0, c, s, 0, -s, c};
                matrix_post_mul(r);
                angle_sin_cos(ay, s, c);
                r = '{c, 0, -s, 0, ONE, 0, s, 0, c};
                matrix_post_mul(r);
                angle_sin_cos(az, s, c);
                r = '{c, s, 0, -s, c, 0, 0, 0, ONE};
                matrix_post_mul(r);
            end
            a3d_pkg::ACT_POINT: begin
                for (int j = 0; j < 3; j++) begin
                    acc = qmul(ax, mat[j]) + qmul(ay, mat[3+j]) + qmul(az, mat[6+j])
                        + mat[9+j];
                    o[j] = 32'(sat32(acc));
                end
                p.x = o[0];
                p.y = o[1];
                p.z = o[2];
                expected_points.push_back(p);
            end
            default: ;
        endcase
    endfunction

    // ---------------- driver ----------------
    int gap_left = 0;
    int burst_left = 1;

    always @(posedge i_clk) begin
        t_item it;
        logic  nv;
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            nv = i_valid;
            if (i_valid && !o_stall) begin
                apply_action('{i_action, i_arg_x, i_arg_y, i_arg_z});
                items_sent++;
                if (i_action == a3d_pkg::ACT_ROT) rotations_sent++;
                nv = 1'b0;
            end
            if (!nv) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_items.size() > 0) begin
                    it = pending_items.pop_front();
                    i_action <= it.action;
                    i_arg_x <= it.ax;
                    i_arg_y <= it.ay;
                    i_arg_z <= it.az;
                    nv = 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
                    end
                end
            end
            i_valid <= nv;
        end
    end

    // ---------------- receiver and checker ----------------
    int stall_run = 0;
    logic stall_val = 1'b0;

    always @(posedge i_clk) begin
        t_point e;
        if (stall_run == 0) begin
            case ($urandom_range(0, 3))
                0: begin stall_val = 1'b0; stall_run = $urandom_range(20, 200); end
                1: begin stall_val = 1'b1; stall_run = $urandom_range(1, 30); end
                default: begin stall_val = $urandom_range(0, 1); stall_run = 1; end
            endcase
        end
        stall_run--;
        i_stall <= stall_val;

        if (i_rst_n && o_valid && !i_stall) begin
            points_seen++;
            if (expected_points.size() == 0) begin
                $error("point beat with nothing expected: %h %h %h", o_out_x, o_out_y, o_out_z);
                errors++;
            end else begin
                e = expected_points.pop_front();
                if (o_out_x !== e.x) begin
                    $error("out_x expected %h got %h", e.x, o_out_x);
                    errors++;
                end
                if (o_out_y !== e.y) begin
                    $error("out_y expected %h got %h", e.y, o_out_y);
                    errors++;
                end
                if (o_out_z !== e.z) begin
                    $error("out_z expected %h got %h", e.z, o_out_z);
                    errors++;
                end
            end
        end

        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    function automatic void add(logic [2:0] a, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        pending_items.push_back('{a, x, y, z});
    endfunction

    function automatic logic [31:0] rnd_scale();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'(int'($urandom_range(0, 262144)) - 131072);
            default: return 32'(int'($urandom_range(40000, 90000)));
        endcase
    endfunction

    function automatic logic [31:0] rnd_angle();
        if ($urandom_range(0, 4) == 0) return $urandom;
        return 32'(int'($urandom_range(0, 2*a3d_pkg::AngleFull)) - a3d_pkg::AngleFull);
    endfunction

    function automatic logic [31:0] rnd_small(int span);
        if ($urandom_range(0, 7) == 0) return $urandom;
        return 32'(int'($urandom_range(0, 2*span)) - span);
    endfunction

    function automatic void add_random();
        case ($urandom_range(0, 19))
            0: add(a3d_pkg::ACT_IDENT, $urandom, $urandom, $urandom);
            1, 2: add(a3d_pkg::ACT_TRANS, rnd_small(1000), rnd_small(1000), rnd_small(1000));
            3, 4: add(a3d_pkg::ACT_SCALE, rnd_scale(), rnd_scale(), rnd_scale());
            5, 6, 7: add(a3d_pkg::ACT_ROT, rnd_angle(), rnd_angle(), rnd_angle());
            8: add(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom);
            9: add(a3d_pkg::ACT_POINT, $urandom, $urandom, $urandom);
            default: add(a3d_pkg::ACT_POINT, rnd_small(1 << 24), rnd_small(1 << 24),
                         rnd_small(1 << 24));
        endcase
    endfunction

    initial begin
        matrix_identity();
        // directed: extremes, every action, folding and saturation corners
        add(a3d_pkg::ACT_POINT, 32'h7fffffff, 32'h80000000, 32'h00010000);
        add(a3d_pkg::ACT_POINT, 32'h0, 32'hffffffff, 32'h0);
        add(a3d_pkg::ACT_TRANS, 32'h7fffffff, 32'h80000000, 32'd3);
        add(a3d_pkg::ACT_POINT, 32'h00010000, 32'h00020000, 32'h00030000);
        add(a3d_pkg::ACT_IDENT, 32'h0, 32'h0, 32'h0);
        add(a3d_pkg::ACT_SCALE, 32'h7fffffff, 32'h80000000, 32'h0);
        add(a3d_pkg::ACT_POINT, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        add(a3d_pkg::ACT_IDENT, 32'h0, 32'h0, 32'h0);
        add(a3d_pkg::ACT_ROT, 32'd5760, -32'sd5760, 32'd11520);
        add(a3d_pkg::ACT_POINT, 32'h00010000, 32'h00010000, 32'h00010000);
        add(a3d_pkg::ACT_ROT, 32'd23040, 32'd5761, -32'sd5761);
        add(a3d_pkg::ACT_ROT, 32'h80000000, 32'h7fffffff, 32'd17280);
        add(a3d_pkg::ACT_POINT, 32'h00123456, 32'hfff00000, 32'h00008000);
        add(a3d_pkg::ACT_ROT, 32'd0, -32'sd11520, -32'sd23040);
        add(3'd5, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        add(3'd6, 32'h0, 32'h0, 32'h0);
        add(3'd7, 32'h12345678, 32'h0, 32'h0);
        add(a3d_pkg::ACT_SCALE, 32'h00008000, 32'hffff0000, 32'h00020000);
        add(a3d_pkg::ACT_TRANS, -32'sd5, 32'd7, 32'd0);
        add(a3d_pkg::ACT_POINT, 32'h80000000, 32'h80000000, 32'h80000000);
        add(a3d_pkg::ACT_IDENT, 32'h0, 32'h0, 32'h0);
        for (int n = 0; n < 1530; n++) add_random();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_items.size() == 0 && items_sent > 0 && !i_valid);
        wait (expected_points.size() == 0);
        repeat (DRAIN) @(posedge i_clk);

        $display("covered %0d actions, %0d rotations, %0d checked points", items_sent,
                 rotations_sent, points_seen);
        if (errors == 0 && expected_points.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
